// ===== sv/b64d_pkg.sv =====
package b64d_pkg;

  // padding character of the encoding
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // sextet codes of the two symbol classes
  localparam logic [5:0] SEXTET_62 = 6'd62;
  localparam logic [5:0] SEXTET_63 = 6'd63;

  // sextets per group and decoded bytes per full group
  localparam int unsigned GROUP_LEN = 4;
  localparam int unsigned BYTES_PER_GROUP = 3;

  // lenient character to sextet mapping, unknown bytes give zero
  function automatic logic [5:0] sextet_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    case (c) inside
      [8'h41:8'h5A]: t = c - 8'd65;   // upper case letters
      [8'h61:8'h7A]: t = c - 8'd71;   // lower case letters
      [8'h30:8'h39]: t = c + 8'd4;    // digits
      8'h2B, 8'h2D, 8'h2E: t = {2'b00, SEXTET_62};
      8'h2F, 8'h2C, 8'h5F: t = {2'b00, SEXTET_63};
      default: t = 8'd0;
    endcase
    return t[5:0];
  endfunction

endpackage

// ===== sv/b64d_ifs.sv =====
// character channel
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

// decoded byte channel
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       msg_end;

  modport source (output valid, output out_byte, output run_last, output msg_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input msg_end,
                output ready);
endinterface

// ===== sv/base64_stream_decoder.sv =====
// Streaming Base64 decoder with a lenient alphabet. One encoded character is
// taken per request on in_ch and decoded bytes leave one per request on
// out_ch. A character is registered on acceptance and decoded in the next
// cycle; the fourth character of a group (or the final character of a
// message) loads up to three bytes into a burst register that drains one
// byte a cycle while out_ch.ready is high, so the first byte passes through
// the input register and then the burst register. Characters that produce no
// byte pass without waiting for the burst register, so a continuous stream
// runs at one character per cycle while the input is not stalled.
// The input stalls only when a byte-producing character meets a burst that
// has not yet drained. run_last marks the last byte of one character's
// burst, msg_end the final byte of the message; a message that ends with a
// tail of one character produces no byte and so no msg_end.
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  b64d_char_if.sink   in_ch,
  b64d_byte_if.source out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // group state
  logic [1:0]  group_pos_r, group_pos_nxt;
  logic [17:0] sextet_acc_r, sextet_acc_nxt;
  logic        third_pad_r, third_pad_nxt;

  // burst register
  logic        b_valid_r;
  logic [23:0] b_word_r;
  logic [1:0]  b_cnt_r;
  logic [1:0]  b_idx_r;
  logic        b_last_r;

  logic [5:0]  sextet;
  logic [23:0] full;
  logic [23:0] word;
  logic [1:0]  count;
  logic        is_pad;
  logic        b_final;
  logic        burst_free;
  logic        s1_take;
  logic        in_take;
  logic        out_take;

  // decode of the registered character
  always_comb begin
    sextet = b64d_pkg::sextet_of(s1_char_r);
    full   = {sextet_acc_r, sextet};
    is_pad = (s1_char_r == b64d_pkg::PAD_CHAR);
    word   = 24'd0;
    count  = 2'd0;
    if (group_pos_r == 2'd3) begin
      word = full;
      if (s1_last_r && is_pad) begin
        count = third_pad_r ? 2'd1 : 2'd2;
      end else begin
        count = 2'(b64d_pkg::BYTES_PER_GROUP);
      end
    end else if (s1_last_r) begin
      count = group_pos_r;
      case (group_pos_r)
        2'd1:    word = {full[11:0], 12'd0};
        2'd2:    word = {full[17:0], 6'd0};
        default: word = 24'd0;
      endcase
    end
  end

  // next group state
  always_comb begin
    group_pos_nxt  = group_pos_r;
    sextet_acc_nxt = sextet_acc_r;
    third_pad_nxt  = third_pad_r;
    if (s1_last_r || group_pos_r == 2'(b64d_pkg::GROUP_LEN - 1)) begin
      group_pos_nxt  = 2'd0;
      sextet_acc_nxt = 18'd0;
      third_pad_nxt  = 1'b0;
    end else begin
      if (group_pos_r == 2'd2) begin
        third_pad_nxt = is_pad;
      end
      sextet_acc_nxt = full[17:0];
      group_pos_nxt  = group_pos_r + 2'd1;
    end
  end

  // handshakes
  assign out_take   = b_valid_r && out_ch.ready;
  assign b_final    = (b_idx_r == b_cnt_r - 2'd1);
  assign burst_free = !b_valid_r || (out_take && b_final);
  assign s1_take    = s1_valid_r && ((count == 2'd0) || burst_free);
  assign in_ch.ready = !s1_valid_r || s1_take;
  assign in_take    = in_ch.valid && in_ch.ready;

  // output byte select
  always_comb begin
    case (b_idx_r)
      2'd0:    out_ch.out_byte = b_word_r[23:16];
      2'd1:    out_ch.out_byte = b_word_r[15:8];
      2'd2:    out_ch.out_byte = b_word_r[7:0];
      default: out_ch.out_byte = 8'd0;
    endcase
  end
  assign out_ch.valid    = b_valid_r;
  assign out_ch.run_last = b_final;
  assign out_ch.msg_end  = b_final && b_last_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      b_valid_r    <= 1'b0;
      group_pos_r  <= 2'd0;
      sextet_acc_r <= 18'd0;
      third_pad_r  <= 1'b0;
      b_idx_r      <= 2'd0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_take) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_take) begin
        group_pos_r  <= group_pos_nxt;
        sextet_acc_r <= sextet_acc_nxt;
        third_pad_r  <= third_pad_nxt;
      end
      if (s1_take && count != 2'd0) begin
        b_valid_r <= 1'b1;
        b_idx_r   <= 2'd0;
      end else if (out_take) begin
        if (b_final) begin
          b_valid_r <= 1'b0;
        end
        b_idx_r <= b_idx_r + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_ch.in_char;
      s1_last_r <= in_ch.in_last;
    end
    if (s1_take && count != 2'd0) begin
      b_word_r <= word;
      b_cnt_r  <= count;
      b_last_r <= s1_last_r;
    end
  end

  // burst index stays inside the burst
  a_idx_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> (b_cnt_r != 2'd0) && (b_idx_r < b_cnt_r))
    else $error("burst index out of range");

  // a final character leaves the group empty
  a_group_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && s1_last_r) |=> (group_pos_r == 2'd0) && (sextet_acc_r == 18'd0))
    else $error("group not cleared after final character");

  // input stalls only behind a held character
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && b_valid_r)
    else $error("input stalled without cause");

  // a burst is never overwritten while bytes remain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !(out_take && b_final)) |-> !(s1_take && count != 2'd0))
    else $error("burst overwritten");

  // an undrained burst keeps its byte
  a_burst_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !out_ch.ready) |=> b_valid_r && $stable(b_idx_r))
    else $error("burst moved without a request");

endmodule
